/* hw/rtl/kfa_pkg.sv */
// shared types, constants and helpers for the keyed fraction accumulator
`timescale 1ns / 1ps

package kfa_pkg;

  localparam int KEY_W  = 24;
  localparam int FRAC_W = 17;
  localparam int SUM_W  = 24;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_EMPTY
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              pair_valid;
    logic [KEY_W-1:0]  key;
    logic [FRAC_W-1:0] frac;
    logic              shift;
  } cell_ctrl_t;

  // saturating add of a fraction onto a running sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                               input logic [FRAC_W-1:0] frac);
    logic [SUM_W:0] total;
    begin
      total = {1'b0, sum} + {{(SUM_W + 1 - FRAC_W){1'b0}}, frac};
      sat_add = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    end
  endfunction

endpackage

/* hw/rtl/kfa_if.sv */
// handshake channels for input pairs and merged result entries
`timescale 1ns / 1ps

interface kfa_in_if;
  logic                         valid;
  logic                         ready;
  logic [kfa_pkg::KEY_W-1:0]    hit_key;
  logic [kfa_pkg::FRAC_W-1:0]   fraction;
  logic                         has_pair;
  logic                         end_of_group;

  modport source (output valid, hit_key, fraction, has_pair, end_of_group, input ready);
  modport sink   (input valid, hit_key, fraction, has_pair, end_of_group, output ready);
endinterface

interface kfa_out_if;
  logic                        valid;
  logic                        ready;
  logic [kfa_pkg::KEY_W-1:0]   out_key;
  logic [kfa_pkg::SUM_W-1:0]   out_sum;
  logic                        last_entry;
  logic                        group_empty;
  logic                        overflowed;

  modport source (output valid, out_key, out_sum, last_entry, group_empty, overflowed,
                  input ready);
  modport sink   (input valid, out_key, out_sum, last_entry, group_empty, overflowed,
                  output ready);
endinterface

/* hw/rtl/kfa_cell.sv */
// one table entry: key match, fraction add, append and shift toward the output
`timescale 1ns / 1ps

module kfa_cell (
  input  logic                      clk,
  input  kfa_pkg::cell_ctrl_t       ctrl,
  input  logic                      used,
  input  logic                      append_sel,
  input  logic [kfa_pkg::KEY_W-1:0] nxt_key,
  input  logic [kfa_pkg::SUM_W-1:0] nxt_sum,
  output logic                      hit,
  output logic [kfa_pkg::KEY_W-1:0] key,
  output logic [kfa_pkg::SUM_W-1:0] sum
);

  // match against the broadcast key, only for occupied entries
  assign hit = used && (key == ctrl.key);

  // shift during drain, otherwise take a new key or accumulate
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= nxt_key;
      sum <= nxt_sum;
    end else if (append_sel) begin
      key <= ctrl.key;
      sum <= {{(kfa_pkg::SUM_W - kfa_pkg::FRAC_W){1'b0}}, ctrl.frac};
    end else if (ctrl.pair_valid && hit) begin
      sum <= kfa_pkg::sat_add(sum, ctrl.frac);
    end
  end

endmodule

/* hw/rtl/keyed_fraction_accumulate.sv */
// top level: chain of table cells plus group controller and output drain
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------
//   pairs    | in  | hit_key, fraction, has_pair, end_of_group
//   entries  | out | out_key, out_sum, last_entry, group_empty, overflowed
//
// a pair item is absorbed as soon as it is accepted: its key is compared against all cells at once
// a group-end item is followed by a drain of n entries (one for an empty group), one entry
// per cycle unless entries stalls, as the chain shifts toward cell 0; pairs are not taken while draining
// rst is synchronous; it clears the controller state, entry count and overflow flag,
// and pairs.ready stays low while it is high
// a stall on entries holds the chain and the shown entry in place
`timescale 1ns / 1ps

module keyed_fraction_accumulate #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  kfa_in_if.sink          pairs,
  kfa_out_if.source       entries
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  kfa_pkg::state_t     state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                overflow, overflow_next;

  kfa_pkg::cell_ctrl_t ctrl;
  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] used;
  logic [TABLE_DEPTH-1:0] append_sel;
  logic [kfa_pkg::KEY_W-1:0] key_q [TABLE_DEPTH];
  logic [kfa_pkg::SUM_W-1:0] sum_q [TABLE_DEPTH];

  logic accept, pair_acc, any_hit, full, append, shift;
  logic [CNT_W-1:0] count_after;

  // input is taken only while idle and out of reset
  assign pairs.ready = !rst && (state == kfa_pkg::ST_IDLE);

  assign accept   = pairs.valid && pairs.ready;
  assign pair_acc = accept && pairs.has_pair;
  assign any_hit  = |hit;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign append   = pair_acc && !any_hit && !full;
  assign count_after = count + CNT_W'(append);
  assign shift    = (state == kfa_pkg::ST_DRAIN) && entries.ready;

  // broadcast to every cell
  assign ctrl = '{pair_valid: pair_acc, key: pairs.hit_key, frac: pairs.fraction,
                  shift: shift};

  // chain of cells, each taking its right neighbor's entry on a shift
  genvar i;
  generate
    for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [kfa_pkg::KEY_W-1:0] nk;
      logic [kfa_pkg::SUM_W-1:0] ns;

      assign used[i]       = CNT_W'(i) < count;
      assign append_sel[i] = append && (count == CNT_W'(i));

      if (i == TABLE_DEPTH - 1) begin : g_tail
        assign nk = '0;
        assign ns = '0;
      end else begin : g_link
        assign nk = key_q[i+1];
        assign ns = sum_q[i+1];
      end

      kfa_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .used       (used[i]),
        .append_sel (append_sel[i]),
        .nxt_key    (nk),
        .nxt_sum    (ns),
        .hit        (hit[i]),
        .key        (key_q[i]),
        .sum        (sum_q[i])
      );
    end
  endgenerate

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= kfa_pkg::ST_IDLE;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  // next state and output channel
  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;

    entries.valid       = 1'b0;
    entries.out_key     = key_q[0];
    entries.out_sum     = sum_q[0];
    entries.last_entry  = (count == CNT_W'(1));
    entries.group_empty = 1'b0;
    entries.overflowed  = overflow;

    case (state)
      kfa_pkg::ST_IDLE: begin
        if (accept) begin
          count_next    = count_after;
          overflow_next = overflow | (pair_acc && !any_hit && full);
          if (pairs.end_of_group) begin
            if (count_after == '0) begin
              state_next = kfa_pkg::ST_EMPTY;
            end else begin
              state_next = kfa_pkg::ST_DRAIN;
            end
          end
        end
      end
      kfa_pkg::ST_DRAIN: begin
        entries.valid = 1'b1;
        if (entries.ready) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next    = kfa_pkg::ST_IDLE;
            overflow_next = 1'b0;
          end
        end
      end
      kfa_pkg::ST_EMPTY: begin
        entries.valid       = 1'b1;
        entries.out_key     = '0;
        entries.out_sum     = '0;
        entries.last_entry  = 1'b1;
        entries.group_empty = 1'b1;
        if (entries.ready) begin
          state_next    = kfa_pkg::ST_IDLE;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next = kfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
